FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition checked on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/runs_pkg.sv
package runs_pkg;

  localparam int TOP_K_DEF      = 8;
  localparam int MAX_SCAN_DEF   = 64;
  localparam int MAX_BUDGET_DEF = 64;

  localparam logic [15:0] SCAN_BUDGET_RST = 16'd64;
  localparam logic [31:0] SAT_MAX         = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_SCAN_BUDGET  = 2'd0,
    CFG_EVENT_COUNT  = 2'd1,
    CFG_VERTEX_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    V_ACCEPT  = 3'd0,
    V_REJECT  = 3'd1,
    V_KEPT    = 3'd2,
    V_DUP     = 3'd3,
    V_INVALID = 3'd4,
    V_NOSCAN  = 3'd5,
    V_FULL    = 3'd6
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

FILE: design/runs_ifs.sv
interface runs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] vertex;
  logic [31:0] cutoff_event;
  logic [31:0] event_index;
  logic [31:0] peer;

  modport source (output valid, action, vertex, cutoff_event, event_index, peer,
                  input ready);
  modport sink (input valid, action, vertex, cutoff_event, event_index, peer,
                output ready);
endinterface

interface runs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [3:0]  slot;
  logic [3:0]  kept_count;
  logic [31:0] scan_total;
  logic [31:0] dup_total;
  logic [31:0] pick_total;
  logic [31:0] rejected_targets;

  modport source (output valid, verdict, slot, kept_count, scan_total,
                  dup_total, pick_total, rejected_targets,
                  input ready);
  modport sink (input valid, verdict, slot, kept_count, scan_total,
                dup_total, pick_total, rejected_targets,
                output ready);
endinterface

interface runs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/runs_ctrl.sv
`include "assert_macros.svh"

module runs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  runs_pkg::sts_t  sts,
  output runs_pkg::cmd_t  cmd
);
  import runs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_load_then_eval, clk, rst_n, cmd.load, cmd.eval, "load not followed by eval")

endmodule

FILE: design/runs_dp.sv
`include "assert_macros.svh"

module runs_dp #(
  parameter int TOP_K      = runs_pkg::TOP_K_DEF,
  parameter int MAX_SCAN   = runs_pkg::MAX_SCAN_DEF,
  parameter int MAX_BUDGET = runs_pkg::MAX_BUDGET_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_action,
  input  logic [31:0]     in_vertex,
  input  logic [31:0]     in_cutoff_event,
  input  logic [31:0]     in_event_index,
  input  logic [31:0]     in_peer,
  input  runs_pkg::cmd_t  cmd,
  output runs_pkg::sts_t  sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_verdict,
  output logic [3:0]      out_slot,
  output logic [3:0]      out_kept_count,
  output logic [31:0]     out_scan_total,
  output logic [31:0]     out_dup_total,
  output logic [31:0]     out_pick_total,
  output logic [31:0]     out_rejected_targets
);
  import runs_pkg::*;

  localparam int KW  = $clog2(TOP_K + 1);
  localparam int IW  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int PW  = $clog2(MAX_SCAN + 1);
  localparam int VSW = $clog2(MAX_BUDGET + 1);

  // configuration
  logic [15:0] budget_cfg_r;
  logic [31:0] event_count_r;
  logic [31:0] vertex_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_cfg_r   <= SCAN_BUDGET_RST;
      event_count_r  <= '0;
      vertex_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCAN_BUDGET:  budget_cfg_r   <= cfg_data[15:0];
        CFG_EVENT_COUNT:  event_count_r  <= cfg_data;
        CFG_VERTEX_COUNT: vertex_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // captured item
  logic        action_r;
  logic [31:0] vertex_r;
  logic [31:0] before_r;
  logic [31:0] event_r;
  logic [31:0] peer_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      vertex_r <= in_vertex;
      before_r <= in_cutoff_event;
      event_r  <= in_event_index;
      peer_r   <= in_peer;
    end
  end

  // per-target state
  logic [31:0]   peers_r [TOP_K];
  logic [KW-1:0] kept_r,   kept_nxt;
  logic [VSW-1:0] seen_r,  seen_nxt;
  logic [PW-1:0] pos_r,    pos_nxt;
  logic [31:0]   cutoff_r, cutoff_nxt;
  logic          target_ok_r, target_ok_nxt;
  logic [31:0]   scanned_r, scanned_nxt;
  logic [31:0]   dup_cnt_r, dup_cnt_nxt;
  logic [31:0]   sel_cnt_r, sel_cnt_nxt;
  logic [31:0]   rej_cnt_r, rej_cnt_nxt;

  // evaluation flags
  logic [VSW-1:0] budget;
  logic           hit;
  logic reject_r, noscan_r, invalid_r, hit_r, full_r;

  always_comb begin
    budget = (budget_cfg_r < 16'(MAX_BUDGET)) ? VSW'(budget_cfg_r) : VSW'(MAX_BUDGET);
    hit = 1'b0;
    for (int i = 0; i < TOP_K; i++) begin
      if ((KW'(i) < kept_r) && (peers_r[i] == peer_r)) begin
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      reject_r  <= (vertex_r >= vertex_count_r) || (before_r > event_count_r);
      noscan_r  <= !target_ok_r || (pos_r >= PW'(MAX_SCAN)) || (seen_r >= budget);
      invalid_r <= (event_r >= cutoff_r) || (event_r >= event_count_r)
                   || (peer_r >= vertex_count_r);
      hit_r     <= hit;
      full_r    <= kept_r >= KW'(TOP_K);
    end
  end

  // commit
  verdict_t   verdict_nxt;
  logic [3:0] slot_nxt;
  logic       peer_we;

  always_comb begin
    kept_nxt      = kept_r;
    seen_nxt      = seen_r;
    pos_nxt       = pos_r;
    cutoff_nxt    = cutoff_r;
    target_ok_nxt = target_ok_r;
    scanned_nxt   = scanned_r;
    dup_cnt_nxt   = dup_cnt_r;
    sel_cnt_nxt   = sel_cnt_r;
    rej_cnt_nxt   = rej_cnt_r;
    slot_nxt      = 4'd0;
    peer_we       = 1'b0;
    verdict_nxt   = V_NOSCAN;
    if (!action_r) begin
      kept_nxt = '0;
      seen_nxt = '0;
      pos_nxt  = '0;
      if (reject_r) begin
        target_ok_nxt = 1'b0;
        cutoff_nxt    = '0;
        rej_cnt_nxt   = sat_inc(rej_cnt_r);
        verdict_nxt   = V_REJECT;
      end else begin
        target_ok_nxt = 1'b1;
        cutoff_nxt    = before_r;
        verdict_nxt   = V_ACCEPT;
      end
    end else if (!noscan_r) begin
      pos_nxt     = pos_r + PW'(1);
      scanned_nxt = sat_inc(scanned_r);
      if (invalid_r) begin
        verdict_nxt = V_INVALID;
      end else begin
        seen_nxt = seen_r + VSW'(1);
        if (hit_r) begin
          dup_cnt_nxt = sat_inc(dup_cnt_r);
          verdict_nxt = V_DUP;
        end else if (!full_r) begin
          peer_we     = 1'b1;
          slot_nxt    = 4'(kept_r);
          kept_nxt    = kept_r + KW'(1);
          sel_cnt_nxt = sat_inc(sel_cnt_r);
          verdict_nxt = V_KEPT;
        end else begin
          verdict_nxt = V_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r      <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      cutoff_r    <= '0;
      target_ok_r <= 1'b0;
      scanned_r   <= '0;
      dup_cnt_r   <= '0;
      sel_cnt_r   <= '0;
      rej_cnt_r   <= '0;
    end else if (cmd.commit) begin
      kept_r      <= kept_nxt;
      seen_r      <= seen_nxt;
      pos_r       <= pos_nxt;
      cutoff_r    <= cutoff_nxt;
      target_ok_r <= target_ok_nxt;
      scanned_r   <= scanned_nxt;
      dup_cnt_r   <= dup_cnt_nxt;
      sel_cnt_r   <= sel_cnt_nxt;
      rej_cnt_r   <= rej_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && peer_we) begin
      peers_r[kept_r[IW-1:0]] <= peer_r;
    end
  end

  // output register
  logic       out_valid_r;
  verdict_t   verdict_r;
  logic [3:0] slot_r;
  logic [3:0] kept_out_r;
  logic [31:0] scanned_out_r, dup_out_r, sel_out_r, rej_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      verdict_r     <= verdict_nxt;
      slot_r        <= slot_nxt;
      kept_out_r    <= 4'(kept_nxt);
      scanned_out_r <= scanned_nxt;
      dup_out_r     <= dup_cnt_nxt;
      sel_out_r     <= sel_cnt_nxt;
      rej_out_r     <= rej_cnt_nxt;
    end
  end

  assign sts.out_free         = !out_valid_r || out_ready;
  assign out_valid            = out_valid_r;
  assign out_verdict          = verdict_r;
  assign out_slot             = slot_r;
  assign out_kept_count       = kept_out_r;
  assign out_scan_total       = scanned_out_r;
  assign out_dup_total        = dup_out_r;
  assign out_pick_total       = sel_out_r;
  assign out_rejected_targets = rej_out_r;

  `ASSERT_ALWAYS(a_kept_bound, clk, rst_n, kept_r <= KW'(TOP_K), "kept count above list size")
  `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_r <= PW'(MAX_SCAN), "scan position above limit")
  `ASSERT_ALWAYS(a_slot_kept, clk, rst_n, !out_valid_r || verdict_r == V_KEPT || slot_r == 4'd0, "slot set on non-kept item")
  `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, out_valid_r, "commit left no result")

endmodule

FILE: design/recent_unique_neighbor_select_core.sv
// an accepted item is captured, evaluated, then committed to the output register
// a new item is taken only once the previous one has been committed (capture, evaluate, commit in the sequencer)
// duplicate check compares all kept slots in parallel during evaluate
// commit waits while the previous result is still held in the output register
// reset (rst_n low, synchronous): no target open, all counts zero, budget 64
module recent_unique_neighbor_select_core #(
  parameter int TOP_K      = runs_pkg::TOP_K_DEF,
  parameter int MAX_SCAN   = runs_pkg::MAX_SCAN_DEF,
  parameter int MAX_BUDGET = runs_pkg::MAX_BUDGET_DEF
) (
  input logic       clk,
  input logic       rst_n,
  runs_in_if.sink   in_ch,
  runs_out_if.source out_ch,
  runs_cfg_if.sink  cfg_ch
);
  import runs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  runs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  runs_dp #(
    .TOP_K      (TOP_K),
    .MAX_SCAN   (MAX_SCAN),
    .MAX_BUDGET (MAX_BUDGET)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_ch.valid),
    .cfg_index            (cfg_ch.index),
    .cfg_data             (cfg_ch.data),
    .in_action            (in_ch.action),
    .in_vertex            (in_ch.vertex),
    .in_cutoff_event      (in_ch.cutoff_event),
    .in_event_index       (in_ch.event_index),
    .in_peer              (in_ch.peer),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_verdict          (out_ch.verdict),
    .out_slot             (out_ch.slot),
    .out_kept_count       (out_ch.kept_count),
    .out_scan_total       (out_ch.scan_total),
    .out_dup_total        (out_ch.dup_total),
    .out_pick_total       (out_ch.pick_total),
    .out_rejected_targets (out_ch.rejected_targets)
  );

endmodule
